### rtl/adcscan_pkg.sv
package adcscan_pkg;

   // Width of the stored raw converter code.
   localparam int SAMPLE_BITS = 12;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [3:0]             chan_type;
   typedef logic [1:0]             op_type;
   typedef logic [2:0]             cmd_type;
   typedef logic [1:0]             pin_type;

   localparam op_type OP_ENABLE  = 2'd0;
   localparam op_type OP_DISABLE = 2'd1;
   localparam op_type OP_READ    = 2'd2;
   localparam op_type OP_POLL    = 2'd3;

   localparam cmd_type CMD_NONE       = 3'd0;
   localparam cmd_type CMD_POWER_UP   = 3'd1;
   localparam cmd_type CMD_POWER_DOWN = 3'd2;
   localparam cmd_type CMD_CALIBRATE  = 3'd3;
   localparam cmd_type CMD_CONVERT    = 3'd4;

   localparam pin_type PIN_NONE     = 2'd0;
   localparam pin_type PIN_ANALOG   = 2'd1;
   localparam pin_type PIN_FLOATING = 2'd2;

   localparam logic [1:0] BANK_A = 2'd0;
   localparam logic [1:0] BANK_B = 2'd1;
   localparam logic [1:0] BANK_C = 2'd2;

   typedef enum logic [2:0] {
      PH_SETUP   = 3'd0,
      PH_START   = 3'd1,
      PH_CONVERT = 3'd2,
      PH_BUSY    = 3'd3,
      PH_RESUME  = 3'd4
   } phase_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] bank;
      logic [3:0] port;
      logic       conv_done;
      sample_type conv_sample;
   } req_type;

   typedef struct packed {
      logic       status;
      sample_type value;
      cmd_type    adc_command;
      chan_type   command_channel;
      pin_type    pin_action;
   } rsp_type;

endpackage

### rtl/adc_channel_scan_controller_top.sv
// A result is registered and presented in the cycle after its request transfer.
// Throughput: one request per cycle; all work is a single combinational pass
// between the request handshake and the result register, with a new request
// taken whenever the result register is empty or being drained.
// Reset (synchronous, active high) returns the phase to setup, clears the
// enable mask, scan counters and reading valid bits; unread readings give zero.
module adc_channel_scan_controller_top
   import adcscan_pkg::*;
#(
   parameter int NUM_CHANNELS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CH_W  = $clog2(NUM_CHANNELS);
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

   typedef logic [CH_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   phase_type               phase_ff, phase_in;
   logic [NUM_CHANNELS-1:0] enable_mask_ff, enable_mask_in;
   idx_type                 scan_list_ff [NUM_CHANNELS];
   idx_type                 snap_list    [NUM_CHANNELS];
   cnt_type                 scan_count_ff, scan_count_in;
   cnt_type                 scan_pos_ff, scan_pos_in;
   sample_type              readings_ff  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] readings_valid_ff, readings_valid_in;
   logic                    snap_en;
   logic                    sample_wr;
   idx_type                 sample_ch;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic                    pin_ok;
   logic [3:0]              ch_raw;
   logic                    ch_ok;
   idx_type                 ch_idx;
   idx_type                 cur_ch;
   cnt_type                 pos_inc;
   cnt_type                 snap_cnt;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Pin to channel mapping.
   always_comb begin
      pin_ok = 1'b0;
      ch_raw = 4'd0;
      case (req_data.bank)
         BANK_A: begin
            pin_ok = req_data.port < 4'd8;
            ch_raw = req_data.port;
         end
         BANK_B: begin
            pin_ok = req_data.port < 4'd2;
            ch_raw = req_data.port + 4'd8;
         end
         BANK_C: begin
            pin_ok = req_data.port < 4'd6;
            ch_raw = req_data.port + 4'd10;
         end
         default: begin
            pin_ok = 1'b0;
            ch_raw = 4'd0;
         end
      endcase
      ch_ok  = pin_ok && ({1'b0, ch_raw} < 5'(NUM_CHANNELS));
      ch_idx = ch_raw[CH_W-1:0];
   end

   // Compaction of the enable mask into an ascending channel list.
   always_comb begin
      snap_cnt = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         snap_list[i] = '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (enable_mask_ff[i]) begin
            snap_list[snap_cnt[CH_W-1:0]] = CH_W'(i);
            snap_cnt = snap_cnt + cnt_type'(1);
         end
      end
   end

   assign cur_ch  = scan_list_ff[scan_pos_ff[CH_W-1:0]];
   assign pos_inc = scan_pos_ff + cnt_type'(1);

   always_comb begin
      logic [NUM_CHANNELS-1:0] bit_sel;
      bit_sel           = '0;
      bit_sel[ch_idx]   = 1'b1;
      phase_in          = phase_ff;
      enable_mask_in    = enable_mask_ff;
      scan_count_in     = scan_count_ff;
      scan_pos_in       = scan_pos_ff;
      readings_valid_in = readings_valid_ff;
      snap_en           = 1'b0;
      sample_wr         = 1'b0;
      sample_ch         = cur_ch;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;

      if (req_fire) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = 1'b0;
         rsp_data_in.value           = '0;
         rsp_data_in.adc_command     = CMD_NONE;
         rsp_data_in.command_channel = '0;
         rsp_data_in.pin_action      = PIN_NONE;

         if (req_data.op == OP_POLL) begin
            if (enable_mask_ff != '0) begin
               case (phase_ff)
                  PH_SETUP: begin
                     rsp_data_in.adc_command = CMD_CALIBRATE;
                     phase_in = PH_START;
                  end
                  PH_START: begin
                     snap_en       = 1'b1;
                     scan_count_in = snap_cnt;
                     scan_pos_in   = '0;
                     phase_in      = PH_CONVERT;
                  end
                  PH_CONVERT: begin
                     rsp_data_in.adc_command     = CMD_CONVERT;
                     rsp_data_in.command_channel = chan_type'(cur_ch);
                     phase_in = PH_BUSY;
                  end
                  PH_BUSY: begin
                     if (req_data.conv_done) begin
                        sample_wr                 = 1'b1;
                        readings_valid_in[cur_ch] = 1'b1;
                        scan_pos_in               = pos_inc;
                        if (pos_inc >= scan_count_ff) begin
                           rsp_data_in.adc_command = CMD_POWER_UP;
                           phase_in = PH_RESUME;
                        end else begin
                           phase_in = PH_CONVERT;
                        end
                     end
                  end
                  PH_RESUME: begin
                     phase_in = PH_SETUP;
                  end
                  default: begin
                     rsp_data_in.adc_command = CMD_POWER_DOWN;
                     phase_in = PH_SETUP;
                  end
               endcase
            end
         end else if (!ch_ok) begin
            rsp_data_in.status = 1'b1;
         end else begin
            case (req_data.op)
               OP_ENABLE: begin
                  // The first enabled channel powers up and clears all readings.
                  if (enable_mask_ff == '0) begin
                     rsp_data_in.adc_command = CMD_POWER_UP;
                     readings_valid_in = '0;
                     phase_in = PH_SETUP;
                  end
                  if (!enable_mask_ff[ch_idx]) begin
                     rsp_data_in.pin_action = PIN_ANALOG;
                     enable_mask_in = enable_mask_ff | bit_sel;
                  end
               end
               OP_DISABLE: begin
                  if (enable_mask_ff[ch_idx]) begin
                     rsp_data_in.pin_action = PIN_FLOATING;
                     enable_mask_in = enable_mask_ff & ~bit_sel;
                  end
                  if (enable_mask_in == '0) begin
                     rsp_data_in.adc_command = CMD_POWER_DOWN;
                     phase_in = PH_SETUP;
                  end
               end
               default: begin
                  if (enable_mask_ff[ch_idx]) begin
                     rsp_data_in.value = readings_valid_ff[ch_idx] ?
                                         readings_ff[ch_idx] : '0;
                  end else begin
                     rsp_data_in.status = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_SETUP;
         enable_mask_ff    <= '0;
         scan_count_ff     <= '0;
         scan_pos_ff       <= '0;
         readings_valid_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         enable_mask_ff    <= enable_mask_in;
         scan_count_ff     <= scan_count_in;
         scan_pos_ff       <= scan_pos_in;
         readings_valid_ff <= readings_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (snap_en) begin
         scan_list_ff <= snap_list;
      end
      if (sample_wr) begin
         readings_ff[sample_ch] <= req_data.conv_sample;
      end
   end

endmodule

### sim/tb_adc_channel_scan_controller_top.sv
`timescale 1ns / 100ps

module tb_adc_channel_scan_controller_top
   import adcscan_pkg::*;
();

   localparam int NUM_CH      = 16;
   localparam int MAX_REPORTS = 10;
   localparam logic [1:0] BANK_NONE = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the sequencer state, advanced once per accepted request.
   phase_type   scan_phase   = PH_SETUP;
   logic [15:0] chan_enabled = '0;
   chan_type    scan_order [16] = '{default: '0};
   logic [4:0]  scan_total   = '0;
   logic [4:0]  scan_index   = '0;
   sample_type  stored_code [16] = '{default: '0};

   rsp_type pending_responses [$];
   int      mismatches       = 0;
   bit      sender_eager     = 1'b0;
   bit      sink_eager       = 1'b0;
   int      long_hold_cycles = 0;

   adc_channel_scan_controller_top #(
      .NUM_CHANNELS(NUM_CH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type predict_scan_response(req_type r);
      rsp_type     e;
      int          ch;
      int          n;
      logic [15:0] chan_bit;
      e = '0;
      if (r.op == OP_POLL) begin
         if (chan_enabled != '0) begin
            case (scan_phase)
               PH_SETUP: begin
                  e.adc_command = CMD_CALIBRATE;
                  scan_phase = PH_START;
               end
               PH_START: begin
                  n = 0;
                  for (int i = 0; i < 16; i++) begin
                     if (chan_enabled[i]) begin
                        scan_order[n] = chan_type'(i);
                        n++;
                     end
                  end
                  scan_total = 5'(n);
                  scan_index = '0;
                  scan_phase = PH_CONVERT;
               end
               PH_CONVERT: begin
                  e.adc_command = CMD_CONVERT;
                  e.command_channel = scan_order[scan_index[3:0]];
                  scan_phase = PH_BUSY;
               end
               PH_BUSY: begin
                  // Without end of conversion the sequencer simply keeps waiting.
                  if (r.conv_done) begin
                     ch = int'(scan_order[scan_index[3:0]]);
                     scan_index = scan_index + 5'd1;
                     stored_code[ch] = r.conv_sample;
                     if (scan_index >= scan_total) begin
                        e.adc_command = CMD_POWER_UP;
                        scan_phase = PH_RESUME;
                     end else begin
                        scan_phase = PH_CONVERT;
                     end
                  end
               end
               PH_RESUME: begin
                  scan_phase = PH_SETUP;
               end
               default: begin
                  e.adc_command = CMD_POWER_DOWN;
                  scan_phase = PH_SETUP;
               end
            endcase
         end
      end else begin
         ch = -1;
         if (r.bank == BANK_A && r.port < 8) ch = int'(r.port);
         else if (r.bank == BANK_B && r.port < 2) ch = int'(r.port) + 8;
         else if (r.bank == BANK_C && r.port < 6) ch = int'(r.port) + 10;
         if (ch >= NUM_CH) ch = -1;
         if (ch < 0) begin
            e.status = 1'b1;
         end else begin
            chan_bit = 16'd1 << ch;
            case (r.op)
               OP_ENABLE: begin
                  // The first enable powers up and wipes the stored codes.
                  if (chan_enabled == '0) begin
                     e.adc_command = CMD_POWER_UP;
                     stored_code = '{default: '0};
                     scan_phase = PH_SETUP;
                  end
                  if ((chan_enabled & chan_bit) == '0) begin
                     e.pin_action = PIN_ANALOG;
                     chan_enabled = chan_enabled | chan_bit;
                  end
               end
               OP_DISABLE: begin
                  if ((chan_enabled & chan_bit) != '0) begin
                     e.pin_action = PIN_FLOATING;
                     chan_enabled = chan_enabled & ~chan_bit;
                  end
                  if (chan_enabled == '0) begin
                     e.adc_command = CMD_POWER_DOWN;
                     scan_phase = PH_SETUP;
                  end
               end
               default: begin
                  if ((chan_enabled & chan_bit) != '0) e.value = stored_code[ch];
                  else e.status = 1'b1;
               end
            endcase
         end
      end
      return e;
   endfunction

   function automatic req_type make_request(op_type op, logic [1:0] bank, logic [3:0] port,
                                            logic done = 1'b0, sample_type sample = '0);
      req_type r;
      r.op          = op;
      r.bank        = bank;
      r.port        = port;
      r.conv_done   = done;
      r.conv_sample = sample;
      return r;
   endfunction

   // Builds a request for the one pin that maps onto the given channel.
   function automatic req_type pin_request(op_type op, int ch, logic done = 1'b0,
                                           sample_type sample = '0);
      req_type r;
      r = make_request(op, BANK_A, 4'(ch), done, sample);
      if (ch >= 10) begin
         r.bank = BANK_C;
         r.port = 4'(ch - 10);
      end else if (ch >= 8) begin
         r.bank = BANK_B;
         r.port = 4'(ch - 8);
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer with
   // valid still high, so back-to-back requests never drop it.
   task automatic send_request(input req_type r);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(predict_scan_response(r));
      @(negedge clock);
   endtask

   task automatic test_pin_mapping_errors();
      send_request(make_request(OP_ENABLE, BANK_NONE, 4'd0));
      send_request(make_request(OP_ENABLE, BANK_A, 4'd8));
      send_request(make_request(OP_READ, BANK_B, 4'd2));
      send_request(make_request(OP_DISABLE, BANK_C, 4'd6));
      send_request(make_request(OP_READ, BANK_NONE, 4'd15));
      // With no channel enabled a poll tick must do nothing at all.
      send_request(make_request(OP_POLL, BANK_NONE, 4'd15, 1'b1, 12'hFFF));
      send_request(pin_request(OP_DISABLE, 9));
      send_request(pin_request(OP_READ, 3));
   endtask

   task automatic test_scan_cycle();
      send_request(pin_request(OP_ENABLE, 0));
      send_request(pin_request(OP_ENABLE, 0));
      send_request(pin_request(OP_ENABLE, 15));
      send_request(make_request(OP_POLL, BANK_A, 4'd0));
      send_request(make_request(OP_POLL, BANK_A, 4'd0));
      send_request(make_request(OP_POLL, BANK_A, 4'd0));
      send_request(make_request(OP_POLL, BANK_A, 4'd0, 1'b0, 12'h123));
      send_request(make_request(OP_POLL, BANK_A, 4'd0, 1'b1, 12'hFFF));
      send_request(make_request(OP_POLL, BANK_A, 4'd0));
      send_request(make_request(OP_POLL, BANK_A, 4'd0, 1'b1, 12'h000));
      send_request(make_request(OP_POLL, BANK_A, 4'd0));
      send_request(pin_request(OP_READ, 0));
      send_request(pin_request(OP_READ, 15));
      send_request(pin_request(OP_DISABLE, 0));
      send_request(pin_request(OP_DISABLE, 0));
      send_request(pin_request(OP_DISABLE, 15));
   endtask

   task automatic test_random_traffic(input int count);
      req_type r;
      int      pick;
      op_type  op;
      for (int k = 0; k < count; k++) begin
         if (k % 50 == 0) begin
            sender_eager = ($urandom_range(0, 4) == 0);
            sink_eager   = ($urandom_range(0, 4) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) op = OP_POLL;
         else if (pick < 70) op = OP_READ;
         else if (pick < 87) op = OP_ENABLE;
         else op = OP_DISABLE;
         if (op == OP_POLL || $urandom_range(0, 9) == 0) begin
            r = make_request(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
         end else begin
            r = pin_request(op, $urandom_range(0, NUM_CH - 1));
         end
         r.conv_done   = ($urandom_range(0, 9) < 7);
         r.conv_sample = sample_type'($urandom_range(0, 4095));
         send_request(r);
         // Now and then empty the mask so that power down and the fresh power up
         // with cleared codes come round again.
         if (k % 240 == 239) begin
            for (int c = 0; c < NUM_CH; c++) send_request(pin_request(OP_DISABLE, c));
         end
      end
      sender_eager = 1'b0;
      sink_eager   = 1'b0;
   endtask

   task automatic test_input_backpressure();
      req_type r;
      long_hold_cycles = 200;
      sender_eager     = 1'b1;
      send_request(pin_request(OP_ENABLE, $urandom_range(0, NUM_CH - 1)));
      for (int k = 0; k < 60; k++) begin
         if (k % 3 == 0) r = pin_request(OP_READ, $urandom_range(0, NUM_CH - 1));
         else r = make_request(OP_POLL, BANK_A, 4'd0, 1'b1,
                               sample_type'($urandom_range(0, 4095)));
         send_request(r);
      end
      sender_eager = 1'b0;
   endtask

   initial begin : response_checker
      rsp_type want;
      int      stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold_cycles > 0) begin
            stall = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            stall = sink_eager ? 0 : $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result transfer with nothing outstanding: %p", $time, rsp_data);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.status !== want.status || rsp_data.value !== want.value ||
                rsp_data.adc_command !== want.adc_command ||
                rsp_data.command_channel !== want.command_channel ||
                rsp_data.pin_action !== want.pin_action) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch: expected status %0d value %03h cmd %0d chan %0d pin %0d,",
                           $time, want.status, want.value, want.adc_command,
                           want.command_channel, want.pin_action,
                           " got status %0d value %03h cmd %0d chan %0d pin %0d",
                           rsp_data.status, rsp_data.value, rsp_data.adc_command,
                           rsp_data.command_channel, rsp_data.pin_action);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_pin_mapping_errors();
      test_scan_cycle();
      test_random_traffic(480);
      test_input_backpressure();
      test_random_traffic(480);
      req_valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/adcscan_pkg.sv
rtl/adc_channel_scan_controller_top.sv
sim/tb_adc_channel_scan_controller_top.sv
